// ===== rtl/cfds_pkg.sv =====
// Package for the crowd-flow direction score block: widths, constants, tables.
// No dependencies.
`default_nettype none
package cfds_pkg;
  localparam int CELLS = 4096;
  localparam int CIDX_W = 12;
  localparam int ADDR_W = 15;
  localparam int DIAG = 46341;
  localparam int PI_Q16 = 205887;
  localparam int TWO_PI_Q16 = 411775;
  localparam int QPI_Q16 = 51472;
  localparam int HPI_Q16 = 102944;
  localparam int TQPI_Q16 = 154416;
  localparam int STEPS = 17;
  localparam logic CFG_CELL_SIZE = 1'b0;
  localparam logic FUNC_WRITE = 1'b0;

  typedef struct packed {
    logic        func;
    logic [2:0]  direction;
    logic [11:0] cell_index;
    logic [15:0] weight;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] heading;
  } item_t;

  function automatic logic [16:0] atan_q16(input logic [4:0] i);
    case (i)
      5'd0: atan_q16 = 17'd51472;
      5'd1: atan_q16 = 17'd30386;
      5'd2: atan_q16 = 17'd16055;
      5'd3: atan_q16 = 17'd8150;
      5'd4: atan_q16 = 17'd4091;
      5'd5: atan_q16 = 17'd2047;
      5'd6: atan_q16 = 17'd1024;
      5'd7: atan_q16 = 17'd512;
      5'd8: atan_q16 = 17'd256;
      5'd9: atan_q16 = 17'd128;
      5'd10: atan_q16 = 17'd64;
      5'd11: atan_q16 = 17'd32;
      5'd12: atan_q16 = 17'd16;
      5'd13: atan_q16 = 17'd8;
      5'd14: atan_q16 = 17'd4;
      5'd15: atan_q16 = 17'd2;
      5'd16: atan_q16 = 17'd1;
      default: atan_q16 = 17'd0;
    endcase
  endfunction
endpackage
`default_nettype wire

// ===== rtl/cfds_queue.sv =====
// Two-entry transaction queue between front and back parts.
// Depends on cfds_pkg.
`default_nettype none
module cfds_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire cfds_pkg::item_t push_item,
  output logic               full,
  output logic               not_empty,
  input  wire logic          pop,
  output cfds_pkg::item_t    head
);
  import cfds_pkg::*;
  item_t mem [2];
  logic wp, rp;
  logic [1:0] count;

  assign full = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= push_item;
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

// ===== rtl/cfds_back.sv =====
// Back part: weight store, cell index divide, vector sum, isqrt, CORDIC, score.
// Depends on cfds_pkg.
`default_nettype none
module cfds_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [7:0]    cell_size,
  input  wire logic [12:0]   grid_width,
  input  wire logic          avail,
  input  wire cfds_pkg::item_t item,
  output logic               pop,
  output logic               valid,
  output logic signed [18:0] flow_score,
  output logic               in_range
);
  import cfds_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_IDX, S_RD, S_SUM, S_RND, S_SQ, S_SQ2, S_ITER, S_SCORE
  } state_t;
  state_t state;

  logic [15:0] grid [CELLS*8];
  logic [15:0] rdata;
  logic [ADDR_W-1:0] raddr;

  item_t cur;
  logic [13:0] span;
  // restoring divider for y and x by span
  logic [15:0] qy, qx, ry, rx;
  logic [4:0] cnt;
  logic [25:0] idx;
  logic [15:0] w [8];
  logic signed [40:0] sx, sy;
  logic signed [26:0] vx, vy;
  logic [51:0] sqv;
  logic [27:0] rem;
  logic [25:0] root;
  logic signed [28:0] cx, cy;
  logic signed [19:0] z;

  // divider step values
  logic [16:0] try_y, try_x;
  logic [15:0] ny, nx;
  always_comb begin
    try_y = {ry[15:0], qy[15]} - {3'd0, span};
    try_x = {rx[15:0], qx[15]} - {3'd0, span};
    ny = try_y[16] ? {ry[14:0], qy[15]} : try_y[15:0];
    nx = try_x[16] ? {rx[14:0], qx[15]} : try_x[15:0];
  end

  // vector part magnitudes for the sum of squares
  logic [25:0] mx, my;
  always_comb begin
    mx = vx[26] ? 26'(-vx) : 26'(vx);
    my = vy[26] ? 26'(-vy) : 26'(vy);
  end

  // isqrt: one result bit per cycle
  logic [29:0] rem_sh;
  logic [27:0] trial;
  logic [30:0] rdiff;
  always_comb begin
    rem_sh = {rem, sqv[51:50]};
    trial = {root, 2'b01};
    rdiff = {1'b0, rem_sh} - {3'd0, trial};
  end

  // cordic step
  logic signed [28:0] dxs, dys;
  logic [16:0] at;
  always_comb begin
    dxs = cy >>> cnt;
    dys = cx >>> cnt;
    at = atan_q16(cnt);
  end

  // score
  logic signed [20:0] d, dd;
  logic [18:0] full, half;
  logic signed [18:0] sc;
  always_comb begin
    d = $signed({z[19], z}) - ($signed(cur.heading) * 21'sd8);
    if (d < 0) d = -d;
    dd = 21'(TWO_PI_Q16) - d;
    if (dd < d) d = dd;
    full = 19'((27'(root) + 27'd128) >> 8);
    half = 19'((27'(root) + 27'd256) >> 9);
    if (d <= 21'(QPI_Q16)) sc = $signed(full);
    else if (d <= 21'(HPI_Q16)) sc = $signed(half);
    else if (d <= 21'(TQPI_Q16)) sc = -$signed(half);
    else sc = -$signed(full);
  end

  always_ff @(posedge clk) begin
    rdata <= grid[raddr];
    if (state == S_IDLE && avail && item.func == FUNC_WRITE && item.cell_index < CELLS)
      grid[{item.cell_index, item.direction}] <= item.weight;
  end

  logic signed [40:0] ax, ay;
  always_comb begin
    ax = (41'(w[1]) - 41'(w[0])) * 41'sd65536
       + (41'(w[5]) + 41'(w[7]) - 41'(w[4]) - 41'(w[6])) * 41'(DIAG);
    ay = (41'(w[2]) - 41'(w[3])) * 41'sd65536
       + (41'(w[4]) + 41'(w[5]) - 41'(w[6]) - 41'(w[7])) * 41'(DIAG);
  end

  always_ff @(posedge clk) begin
    pop <= 1'b0;
    valid <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: if (avail && !pop) begin
          pop <= 1'b1;
          cur <= item;
          if (item.func != FUNC_WRITE) begin
            span <= {cell_size, 6'd0};
            qy <= item.pos_y; qx <= item.pos_x; ry <= '0; rx <= '0;
            cnt <= 5'd0;
            if (cell_size == 8'd0) begin
              valid <= 1'b1; flow_score <= '0; in_range <= 1'b0;
            end else state <= S_DIV;
          end
        end
        S_DIV: begin
          ry <= ny; rx <= nx;
          qy <= {qy[14:0], ~try_y[16]};
          qx <= {qx[14:0], ~try_x[16]};
          cnt <= cnt + 5'd1;
          if (cnt == 5'd15) state <= S_IDX;
        end
        S_IDX: begin
          idx <= 26'(qy) * 26'(grid_width) + 26'(qx);
          cnt <= 5'd0;
          state <= S_RD;
        end
        S_RD: begin
          if (idx >= 26'(CELLS)) begin
            valid <= 1'b1; flow_score <= '0; in_range <= 1'b0;
            state <= S_IDLE;
          end else begin
            // read the eight weights, one per cycle, through the registered address and read data
            if (cnt <= 5'd7) raddr <= {idx[CIDX_W-1:0], cnt[2:0]};
            if (cnt >= 5'd2) w[3'(cnt - 5'd2)] <= rdata;
            cnt <= cnt + 5'd1;
            if (cnt == 5'd9) state <= S_SUM;
          end
        end
        S_SUM: begin
          sx <= ax; sy <= ay; state <= S_RND;
        end
        S_RND: begin
          vx <= 27'((sx + 41'sd128) >>> 8);
          vy <= 27'((sy + 41'sd128) >>> 8);
          state <= S_SQ;
        end
        S_SQ: begin
          sqv <= 52'(mx) * 52'(mx) + 52'(my) * 52'(my);
          rem <= '0; root <= '0; cnt <= 5'd0;
          if (vx < 0) begin
            cx <= -29'(vx); cy <= -29'(vy);
            z <= (vy >= 0) ? 20'(PI_Q16) : -20'(PI_Q16);
          end else begin
            cx <= 29'(vx); cy <= 29'(vy); z <= '0;
          end
          state <= S_ITER;
        end
        S_ITER: begin
          sqv <= {sqv[49:0], 2'b00};
          if (!rdiff[30]) begin
            rem <= rdiff[27:0];
            root <= {root[24:0], 1'b1};
          end else begin
            rem <= rem_sh[27:0];
            root <= {root[24:0], 1'b0};
          end
          if (cnt < 5'(STEPS)) begin
            if (cy > 0) begin
              cx <= cx + dxs; cy <= cy - dys; z <= z + 20'(at);
            end else begin
              cx <= cx - dxs; cy <= cy + dys; z <= z - 20'(at);
            end
          end
          cnt <= cnt + 5'd1;
          if (cnt == 5'd25) state <= S_SCORE;
        end
        S_SCORE: begin
          valid <= 1'b1; flow_score <= sc; in_range <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/crowd_flow_direction_score.sv =====
// Top level: configuration registers, input front end, queue, back end.
// Depends on cfds_pkg, cfds_queue, cfds_back.
// With the back end idle, a write is stored when the back end takes it; a query strobes
// its result after the index divide, the weight read and the square root with CORDIC
// alongside, an off-store cell after the index divide, a zero cell size when it is taken.
// The back end takes no new item until it has finished with the last one.
// busy rises only when the two-entry queue is full. The receiver cannot stall.
// Reset: cell_size = 1, grid_width = 64, queue empty; the weight store is not cleared.
`default_nettype none
module crowd_flow_direction_score (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               func,
  input  wire logic [2:0]         direction,
  input  wire logic [11:0]        cell_index,
  input  wire logic [15:0]        weight,
  input  wire logic [15:0]        pos_x,
  input  wire logic [15:0]        pos_y,
  input  wire logic signed [15:0] heading,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [12:0]        cfg_data,
  output logic                    result_valid,
  output logic signed [18:0]      flow_score,
  output logic                    in_range
);
  import cfds_pkg::*;
  logic [7:0] cell_size;
  logic [12:0] grid_width;
  item_t in_item, head;
  logic not_empty, pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_size <= 8'd1;
      grid_width <= 13'd64;
    end else if (cfg_we) begin
      if (cfg_index == CFG_CELL_SIZE) cell_size <= cfg_data[7:0];
      else grid_width <= cfg_data;
    end
  end

  assign in_item = '{func, direction, cell_index, weight, pos_x, pos_y, heading};

  cfds_queue u_queue (
    .clk, .rst, .push(start && !busy), .push_item(in_item), .full(busy),
    .not_empty, .pop, .head
  );

  cfds_back u_back (
    .clk, .rst, .cell_size, .grid_width, .avail(not_empty), .item(head), .pop,
    .valid(result_valid), .flow_score, .in_range
  );
endmodule
`default_nettype wire
